/* src/crm_pkg.sv */
// Package for the counter delta rate meter.
// Holds widths, rate scales, overflow limits and the controller/datapath link types.
package crm_pkg;

  localparam int unsigned LinkW = 32;
  localparam int unsigned CntW = 64;
  localparam int unsigned PktRateW = 32;
  localparam int unsigned DivCntW = 7;
  localparam logic [DivCntW-1:0] DivSteps = 7'd64;
  localparam int unsigned ScaleW = 23;
  localparam int unsigned HalfW = CntW / 2;

  localparam logic [CntW-1:0] PktScale = 64'd1000000;
  localparam logic [CntW-1:0] BitScale = 64'd8000000;
  localparam logic [CntW-1:0] PktLimit = 64'hFFFF_FFFF_FFFF_FFFF / PktScale;
  localparam logic [CntW-1:0] BitLimit = 64'hFFFF_FFFF_FFFF_FFFF / BitScale;
  localparam logic [CntW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CntW-1:0] Max32 = 64'h0000_0000_FFFF_FFFF;

  localparam logic [1:0] ResSat = 2'd0;
  localparam logic [1:0] ResAcc = 2'd1;
  localparam logic [1:0] ResSum = 2'd2;

  localparam logic MulSrcQuo = 1'b0;
  localparam logic MulSrcRem = 1'b1;
  localparam logic DivSrcNum = 1'b0;
  localparam logic DivSrcProd = 1'b1;

  typedef struct packed {
    logic       snap_load;
    logic       base_clear;
    logic       base_load;
    logic       dt_load;
    logic       div_start;
    logic       div_src;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_sum;
    logic       mul_src;
    logic       acc_load;
    logic       res_write;
    logic [1:0] res_sel;
    logic [1:0] idx;
    logic       out_write;
    logic       out_flag;
  } crm_cmd_t;

  typedef struct packed {
    logic stats_valid;
    logic rebase;
    logic div_busy;
    logic q_over;
    logic r_zero;
    logic r_over;
  } crm_status_t;

  function automatic logic [PktRateW-1:0] sat32(input logic [CntW-1:0] v);
    return (v > Max32) ? Max32[PktRateW-1:0] : v[PktRateW-1:0];
  endfunction

endpackage

/* src/crm_if.sv */
// Handshake channels for the rate meter: snapshot input and rate output.
// Depends on crm_pkg for field widths.
interface crm_snap_if import crm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            stats_valid;
  logic [LinkW-1:0] link_id;
  logic [CntW-1:0] now_us;
  logic [CntW-1:0] tx_bytes_total;
  logic [CntW-1:0] rx_bytes_total;
  logic [CntW-1:0] tx_packets_total;
  logic [CntW-1:0] rx_packets_total;
  modport source (output valid, stats_valid, link_id, now_us, tx_bytes_total,
                  rx_bytes_total, tx_packets_total, rx_packets_total, input ready);
  modport sink (input valid, stats_valid, link_id, now_us, tx_bytes_total,
                rx_bytes_total, tx_packets_total, rx_packets_total, output ready);
endinterface

interface crm_rate_if import crm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                rate_valid;
  logic [PktRateW-1:0] tx_packet_rate;
  logic [PktRateW-1:0] rx_packet_rate;
  logic [CntW-1:0]     tx_bit_rate;
  logic [CntW-1:0]     rx_bit_rate;
  logic [CntW-1:0]     rate_time_us;
  modport source (output valid, rate_valid, tx_packet_rate, rx_packet_rate, tx_bit_rate,
                  rx_bit_rate, rate_time_us, input ready);
  modport sink (input valid, rate_valid, tx_packet_rate, rx_packet_rate, tx_bit_rate,
                rx_bit_rate, rate_time_us, output ready);
endinterface

/* src/crm_datapath.sv */
// Datapath of the rate meter: snapshot and baseline registers, shared divider,
// constant multiplier, result registers and output word. Depends on crm_pkg.
module crm_datapath import crm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  crm_cmd_t      cmd,
  output crm_status_t   status,
  crm_snap_if.sink      snap,
  crm_rate_if.source    rate
);

  logic            s_valid;
  logic [LinkW-1:0] s_link;
  logic [CntW-1:0] s_now, s_txb, s_rxb, s_txp, s_rxp;
  logic            b_present;
  logic [LinkW-1:0] b_link;
  logic [CntW-1:0] b_time, b_txb, b_rxb, b_txp, b_rxp;
  logic [CntW-1:0] dt;
  logic [CntW-1:0] dv_rem, dv_quo;
  logic [DivCntW-1:0] dv_cnt;
  logic            dv_busy;
  logic [CntW-1:0] mlo, mhi, prod, acc;
  logic [CntW-1:0] res [4];
  logic [CntW-1:0] num, scale, limit, mul_op;
  logic [CntW:0]   shifted, diff, sum;

  always_comb begin
    case (cmd.idx)
      2'd0: num = s_txp - b_txp;
      2'd1: num = s_rxp - b_rxp;
      2'd2: num = s_txb - b_txb;
      default: num = s_rxb - b_rxb;
    endcase
    scale = cmd.idx[1] ? BitScale : PktScale;
    limit = cmd.idx[1] ? BitLimit : PktLimit;
    mul_op = (cmd.mul_src == MulSrcRem) ? dv_rem : dv_quo;
    shifted = {dv_rem, dv_quo[CntW-1]};
    diff = shifted - {1'b0, dt};
    sum = {1'b0, acc} + {1'b0, dv_quo};
  end

  assign status.stats_valid = s_valid;
  assign status.rebase = !b_present || (b_link != s_link) || (s_now <= b_time) ||
                         (s_txb < b_txb) || (s_rxb < b_rxb) ||
                         (s_txp < b_txp) || (s_rxp < b_rxp);
  assign status.div_busy = dv_busy;
  assign status.q_over = dv_quo > limit;
  assign status.r_zero = dv_rem == '0;
  assign status.r_over = dv_rem > limit;

  always_ff @(posedge clk) begin
    if (cmd.snap_load) begin
      s_valid <= snap.stats_valid;
      s_link <= snap.link_id;
      s_now <= snap.now_us;
      s_txb <= snap.tx_bytes_total;
      s_rxb <= snap.rx_bytes_total;
      s_txp <= snap.tx_packets_total;
      s_rxp <= snap.rx_packets_total;
    end
    if (cmd.dt_load) begin
      dt <= s_now - b_time;
    end
    if (cmd.div_start) begin
      dv_quo <= (cmd.div_src == DivSrcProd) ? prod : num;
      dv_rem <= '0;
    end else if (dv_busy) begin
      if (!diff[CntW]) begin
        dv_rem <= diff[CntW-1:0];
        dv_quo <= {dv_quo[CntW-2:0], 1'b1};
      end else begin
        dv_rem <= shifted[CntW-1:0];
        dv_quo <= {dv_quo[CntW-2:0], 1'b0};
      end
    end
    if (cmd.mul_lo) begin
      mlo <= CntW'(mul_op[HalfW-1:0] * scale[ScaleW-1:0]);
    end
    if (cmd.mul_hi) begin
      mhi <= CntW'(mul_op[CntW-1:HalfW] * scale[ScaleW-1:0]);
    end
    if (cmd.mul_sum) begin
      prod <= mlo + {mhi[HalfW-1:0], {HalfW{1'b0}}};
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end
    if (cmd.res_write) begin
      case (cmd.res_sel)
        ResAcc: res[cmd.idx] <= acc;
        ResSum: res[cmd.idx] <= sum[CntW] ? AllOnes : sum[CntW-1:0];
        default: res[cmd.idx] <= AllOnes;
      endcase
    end
    if (cmd.out_write) begin
      rate.rate_valid <= cmd.out_flag;
      rate.tx_packet_rate <= cmd.out_flag ? sat32(res[0]) : '0;
      rate.rx_packet_rate <= cmd.out_flag ? sat32(res[1]) : '0;
      rate.tx_bit_rate <= cmd.out_flag ? res[2] : '0;
      rate.rx_bit_rate <= cmd.out_flag ? res[3] : '0;
      rate.rate_time_us <= cmd.out_flag ? s_now : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt <= '0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
      dv_cnt <= DivSteps;
    end else if (dv_busy) begin
      dv_cnt <= dv_cnt - 1'b1;
      dv_busy <= dv_cnt != 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.base_clear) begin
      b_present <= 1'b0;
      b_link <= '0;
      b_time <= '0;
      b_txb <= '0;
      b_rxb <= '0;
      b_txp <= '0;
      b_rxp <= '0;
    end else if (cmd.base_load) begin
      b_present <= 1'b1;
      b_link <= s_link;
      b_time <= s_now;
      b_txb <= s_txb;
      b_rxb <= s_rxb;
      b_txp <= s_txp;
      b_rxp <= s_rxp;
    end
  end

endmodule

/* src/crm_ctrl.sv */
// Controller of the rate meter: sequences the four scaled ratios per word.
// Depends on crm_pkg for the command and status types.
module crm_ctrl import crm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  crm_status_t status,
  output crm_cmd_t    cmd
);

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SEval = 5'd1;
  localparam logic [4:0] SDiv1 = 5'd2;
  localparam logic [4:0] SWait1 = 5'd3;
  localparam logic [4:0] SQChk = 5'd4;
  localparam logic [4:0] SQHi = 5'd5;
  localparam logic [4:0] SQSum = 5'd6;
  localparam logic [4:0] SQAcc = 5'd7;
  localparam logic [4:0] SRChk = 5'd8;
  localparam logic [4:0] SRHi = 5'd9;
  localparam logic [4:0] SRSum = 5'd10;
  localparam logic [4:0] SDiv2 = 5'd11;
  localparam logic [4:0] SWait2 = 5'd12;
  localparam logic [4:0] SAdd = 5'd13;
  localparam logic [4:0] SNext = 5'd14;
  localparam logic [4:0] SOut = 5'd15;

  logic [4:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic       flag, flag_next;
  logic       out_free;

  assign in_ready = state == SIdle;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    state_next = state;
    idx_next = idx;
    flag_next = flag;
    case (state)
      SIdle: begin
        cmd.snap_load = in_valid;
        if (in_valid) state_next = SEval;
      end
      SEval: begin
        cmd.dt_load = 1'b1;
        idx_next = 2'd0;
        if (!status.stats_valid) begin
          cmd.base_clear = 1'b1;
          flag_next = 1'b0;
          state_next = SOut;
        end else if (status.rebase) begin
          cmd.base_load = 1'b1;
          flag_next = 1'b0;
          state_next = SOut;
        end else begin
          flag_next = 1'b1;
          state_next = SDiv1;
        end
      end
      SDiv1: begin
        cmd.div_start = 1'b1;
        cmd.div_src = DivSrcNum;
        state_next = SWait1;
      end
      SWait1: if (!status.div_busy) state_next = SQChk;
      SQChk: begin
        if (status.q_over) begin
          cmd.res_write = 1'b1;
          cmd.res_sel = ResSat;
          state_next = SNext;
        end else begin
          cmd.mul_lo = 1'b1;
          cmd.mul_src = MulSrcQuo;
          state_next = SQHi;
        end
      end
      SQHi: begin
        cmd.mul_hi = 1'b1;
        cmd.mul_src = MulSrcQuo;
        state_next = SQSum;
      end
      SQSum: begin
        cmd.mul_sum = 1'b1;
        state_next = SQAcc;
      end
      SQAcc: begin
        cmd.acc_load = 1'b1;
        state_next = SRChk;
      end
      SRChk: begin
        if (status.r_zero) begin
          cmd.res_write = 1'b1;
          cmd.res_sel = ResAcc;
          state_next = SNext;
        end else if (status.r_over) begin
          cmd.res_write = 1'b1;
          cmd.res_sel = ResSat;
          state_next = SNext;
        end else begin
          cmd.mul_lo = 1'b1;
          cmd.mul_src = MulSrcRem;
          state_next = SRHi;
        end
      end
      SRHi: begin
        cmd.mul_hi = 1'b1;
        cmd.mul_src = MulSrcRem;
        state_next = SRSum;
      end
      SRSum: begin
        cmd.mul_sum = 1'b1;
        state_next = SDiv2;
      end
      SDiv2: begin
        cmd.div_start = 1'b1;
        cmd.div_src = DivSrcProd;
        state_next = SWait2;
      end
      SWait2: if (!status.div_busy) state_next = SAdd;
      SAdd: begin
        cmd.res_write = 1'b1;
        cmd.res_sel = ResSum;
        state_next = SNext;
      end
      SNext: begin
        idx_next = idx + 2'd1;
        state_next = (idx == 2'd3) ? SOut : SDiv1;
      end
      SOut: begin
        if (out_free) begin
          cmd.out_write = 1'b1;
          cmd.out_flag = flag;
          cmd.base_load = flag;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      idx <= '0;
      flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      flag <= flag_next;
      if (cmd.out_write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/counter_delta_rate_meter.sv */
// Top level of the counter delta rate meter.
// Depends on crm_pkg, crm_if, crm_ctrl and crm_datapath.
//
// The snap channel takes one word per counter snapshot; the rate channel
// returns exactly one word per snapshot, in order. A snapshot with
// stats_valid low clears the baseline; one that cannot be compared with the
// baseline (none stored, other link, time not advanced, a counter gone back)
// replaces it. Both give a word with rate_valid low and all fields zero.
// Otherwise four scaled ratios are formed one after another on a single
// restoring divider that retires one quotient bit per cycle, with a
// constant multiplier split into two 32-bit halves.
// An invalid or rebaseline snapshot goes from evaluation straight to the
// output register. A computed snapshot needs four to eight divider passes:
// one per ratio, plus one when neither limit is hit and the remainder is not zero.
// One snapshot is worked on at a time; snap.ready is high only when idle.
// The output register holds a finished word while the receiver stalls, and
// the next snapshot is accepted and worked on meanwhile; it then waits for
// the register to free. Reset clears the baseline and empties the output.
module counter_delta_rate_meter import crm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  crm_snap_if.sink   snap,
  crm_rate_if.source rate
);

  crm_cmd_t    cmd;
  crm_status_t status;

  crm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (snap.valid),
    .in_ready  (snap.ready),
    .out_valid (rate.valid),
    .out_ready (rate.ready),
    .status    (status),
    .cmd       (cmd)
  );

  crm_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .snap   (snap),
    .rate   (rate)
  );

endmodule

/* src/crm_checker.sv */
// Port checker for the counter delta rate meter, bound to the top level.
// Depends on crm_pkg for field widths.
module crm_checker import crm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                rate_valid,
  input logic [PktRateW-1:0] tx_packet_rate,
  input logic [PktRateW-1:0] rx_packet_rate,
  input logic [CntW-1:0]     tx_bit_rate,
  input logic [CntW-1:0]     rx_bit_rate,
  input logic [CntW-1:0]     rate_time_us
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("rate word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(rate_time_us) && $stable(tx_bit_rate))
    else $error("rate word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second snapshot taken");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rate_valid |-> tx_packet_rate == '0 && rx_packet_rate == '0 &&
      tx_bit_rate == '0 && rx_bit_rate == '0 && rate_time_us == '0)
    else $error("invalid rate word not cleared");

  a_valid_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_valid |-> rate_time_us != '0)
    else $error("computed rate without advanced time");

endmodule

bind counter_delta_rate_meter crm_checker u_crm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (snap.valid),
  .in_ready       (snap.ready),
  .out_valid      (rate.valid),
  .out_ready      (rate.ready),
  .rate_valid     (rate.rate_valid),
  .tx_packet_rate (rate.tx_packet_rate),
  .rx_packet_rate (rate.rx_packet_rate),
  .tx_bit_rate    (rate.tx_bit_rate),
  .rx_bit_rate    (rate.rx_bit_rate),
  .rate_time_us   (rate.rate_time_us)
);
